@@ hdl/sorted_priority_queue_core_defines.svh @@
// Assertion macros for the checker file.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

@@ hdl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PRI_W  = 16;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } spq_ctrl_t;

endpackage

@@ hdl/sorted_priority_queue_core.sv @@
// Channel | Direction | Handshake             | Payload
// in      | into core | in_valid_i/in_stall_o  | action_i, item_value_i, item_priority_i
// out     | from core | out_valid_o/out_stall_i| out_value_o, out_priority_o, status_o,
//         |           |                        | occupancy_o
//
// Every item passes through the cell chain; one item can enter per cycle while in_stall_o is low.
// The result appears in the output register the cycle after acceptance.
// in_stall_o is high only while a result waits and out_stall_i holds it.
// Reset clears the entry count and the output valid; cell contents stay undefined.
// Only cells below the count are ever read, so no clearing pass is needed.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [VAL_W-1:0]  item_value_i,
  input  logic signed [PRI_W-1:0]  item_priority_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [VAL_W-1:0]  out_value_o,
  output logic signed [PRI_W-1:0]  out_priority_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_value_q, out_value_d;
  logic [PRI_W-1:0]    out_prio_q, out_prio_d;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [OCC_W-1:0]    occ_q, occ_d;

  logic                accept;
  logic                is_ins, is_read, full, empty;
  logic [CntW+OCC_W-1:0] count_ext;
  spq_ctrl_t           ctrl;
  entry_t              cell_entry [CAPACITY];
  logic                cell_keep  [CAPACITY];

  // Take a new item unless a finished result is held by the consumer.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_ins  = (action_i == ACT_INSERT);
  assign is_read = (action_i == ACT_REMOVE) || (action_i == ACT_PEEK);
  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);

  // Drive the chain: insert shifts toward the tail, remove toward the head.
  assign ctrl.insert          = accept && is_ins && !full;
  assign ctrl.remove          = accept && (action_i == ACT_REMOVE) && !empty;
  assign ctrl.new_entry.value = item_value_i;
  assign ctrl.new_entry.prio  = item_priority_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occupied;
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .left_keep_i  (left_keep),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (cell_entry[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // Advance the count with the chain.
  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Zero-extend the count; its low bits fill the occupancy field.
  assign count_ext = {{OCC_W{1'b0}}, count_d};

  // Build the result from the head cell as it stands before the update.
  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_prio_d  = out_prio_q;
    status_d    = status_q;
    occ_d       = occ_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      out_prio_d  = '0;
      status_d    = STAT_OK;
      occ_d       = count_ext[OCC_W-1:0];
      if (is_ins && full) begin
        status_d = STAT_FULL;
      end else if (is_read && empty) begin
        status_d = STAT_EMPTY;
      end else if (is_read) begin
        out_value_d = cell_entry[0].value;
        out_prio_d  = cell_entry[0].prio;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers without reset.
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_prio_q  <= out_prio_d;
    status_q    <= status_d;
    occ_q       <= occ_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_prio_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;

endmodule

@@ hdl/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  spq_ctrl_t ctrl_i,
  input  logic      occupied_i,
  input  logic      left_keep_i,
  input  entry_t    left_entry_i,
  input  entry_t    right_entry_i,
  output entry_t    entry_o,
  output logic      keep_o
);

  entry_t entry_q;
  entry_t entry_d;

  // Stay in place on insert when held priority is at least the new one.
  assign keep_o  = occupied_i &&
                   ($signed(entry_q.prio) >= $signed(ctrl_i.new_entry.prio));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.new_entry : left_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hdl/spq_checker.sv @@
`include "sorted_priority_queue_core_defines.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VAL_W-1:0] out_value_o,
  input logic signed [PRI_W-1:0] out_priority_o,
  input logic [STAT_W-1:0]       status_o,
  input logic [OCC_W-1:0]        occupancy_o
);

  localparam int unsigned CapW = $clog2(CAPACITY + 1) + OCC_W;
  localparam logic [CapW-1:0] CapExt = CapW'(CAPACITY);

  // A held result keeps its value, status and occupancy.
  `SPQ_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_value_o) && $stable(status_o) && $stable(occupancy_o))

  // An empty report returns nothing and shows an empty queue.
  `SPQ_ASSERT_NOW(a_empty, out_valid_o && (status_o == STAT_EMPTY),
    (occupancy_o == '0) && (out_value_o == '0) && (out_priority_o == '0))

  // A full report shows the queue at capacity.
  `SPQ_ASSERT_NOW(a_full, out_valid_o && (status_o == STAT_FULL),
    (occupancy_o == CapExt[OCC_W-1:0]) && (out_value_o == '0))

  // No status code beyond full is ever produced.
  `SPQ_ASSERT_NOW(a_status, out_valid_o,
    (status_o == STAT_OK) || (status_o == STAT_EMPTY) || (status_o == STAT_FULL))

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
